@@ src/cma_pkg.sv @@
// shared constants for the centered moving average core
// no dependencies; used by centered_moving_average_core and its testbench
package cma_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 63;
  localparam int WIN_BITS    = 6;
  localparam int SUM_BITS    = 22;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int CNT_BITS    = 5;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd9;

  // register word index, decoded on address bit 2
  localparam logic REG_WINDOW = 1'b0;

endpackage

@@ src/centered_moving_average_core.sv @@
// centered moving average core: running sum, circular delay line in a
// synchronous memory, bit-serial divider and an output register
// depends on cma_pkg
//
// Smooths a record of signed 16-bit samples with a centered moving average
// over an odd window W (window_length with bit 0 forced high, reset 9).
// Input words carry one sample, in_tlast marks the last sample of a record.
// While the window fills, a sample gives no output.
// The sample that fills the window gives W/2 copies of the record's first
// sample and then the first average; every later sample gives one average
// (sum / W truncated toward zero). The last sample of a record also gives
// W/2 more copies of the last average. A record shorter than W gives one
// copy of its first sample per sample, all at its end. out_tlast marks the
// last word caused by one input, out_tuser[0] the last word of a record.
// Timing: a sample after the fill goes through the delay line read, the
// sum update and the one-bit-per-cycle divider; its output words then
// leave one per cycle while out_tready allows, and the divider sets the
// sustained rate once the window is full. A new word is taken while the
// last output word still waits in the output register. Window writes are
// ignored in the middle of a record.
module centered_moving_average_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cma_pkg::SAMPLE_BITS-1:0] in_tdata,   // [15:0] sample
  input  logic                           in_tlast,   // record_end
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cma_pkg::SAMPLE_BITS-1:0] out_tdata,  // [15:0] average
  output logic                           out_tlast,  // run_end
  output logic [0:0]                     out_tuser,  // [0] record_done
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cma_pkg::ADDR_BITS-1:0]  cfg_paddr,
  input  logic [cma_pkg::DATA_BITS-1:0]  cfg_pwdata,
  output logic [cma_pkg::DATA_BITS-1:0]  cfg_prdata,
  output logic                           cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_FIRST,
    S_AVG
  } state_t;

  localparam int SB = cma_pkg::SAMPLE_BITS;
  localparam int WB = cma_pkg::WIN_BITS;
  localparam int UB = cma_pkg::SUM_BITS;
  localparam int CB = cma_pkg::CNT_BITS;

  state_t                state_r;
  logic [WB-1:0]         wl_r;
  logic [WB-1:0]         fill_r;
  logic [WB-1:0]         ptr_r;
  logic signed [UB-1:0]  sum_r;
  logic [SB-1:0]         first_r;
  logic [SB-1:0]         avg_r;
  logic [SB-1:0]         x_r;
  logic                  end_r;
  logic [WB-1:0]         first_left_r;
  logic [WB-1:0]         avg_left_r;
  // divider
  logic [UB-1:0]         div_q_r;
  logic [WB-1:0]         div_rem_r;
  logic                  div_neg_r;
  logic [CB-1:0]         div_cnt_r;
  // output register
  logic                  out_tvalid_r;
  logic [SB-1:0]         out_data_r;
  logic                  out_last_r;
  logic                  out_done_r;

  // delay line memory
  logic [SB-1:0]         mem [cma_pkg::MAX_WINDOW];
  logic [SB-1:0]         rd_data_r;
  logic                  mem_we;
  logic [WB-1:0]         mem_waddr;
  logic [SB-1:0]         mem_wdata;

  logic [WB-1:0]         win;
  logic [WB-1:0]         half;
  logic [WB-1:0]         fill_inc;
  logic [WB-1:0]         ptr_inc;
  logic                  in_acc;
  logic                  filling;
  logic signed [UB-1:0]  sum_fill;
  logic signed [UB-1:0]  sum_slide;
  logic [WB-1:0]         avg_cnt_in;
  logic [WB-1:0]         avg_cnt_x;
  logic [WB:0]           div_shift;
  logic                  div_ge;
  logic [WB:0]           div_diff;
  logic [WB-1:0]         div_rem_nxt;
  logic [UB-1:0]         div_q_nxt;
  logic [UB-1:0]         div_res;
  logic                  load_ok;
  logic                  out_load;
  logic                  cfg_wr;
  logic                  last_first;

  // effective window: force odd
  assign win      = {wl_r[WB-1:1], 1'b1};
  assign half     = {1'b0, wl_r[WB-1:1]};
  assign fill_inc = fill_r + 1'b1;
  assign ptr_inc  = (ptr_r == win - 1'b1) ? '0 : ptr_r + 1'b1;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign filling   = (fill_r < win);

  // sum while filling, and sliding sum once full (new in, oldest out)
  assign sum_fill  = sum_r + UB'(signed'(in_tdata));
  assign sum_slide = sum_r + UB'(signed'(x_r)) - UB'(signed'(rd_data_r));

  // averages still owed by this input: one, plus the tail at record end
  assign avg_cnt_in = in_tlast ? half + 1'b1 : WB'(1);
  assign avg_cnt_x  = end_r    ? half + 1'b1 : WB'(1);

  // one restoring divide step per cycle
  assign div_shift   = {div_rem_r, div_q_r[UB-1]};
  assign div_ge      = (div_shift >= {1'b0, win});
  assign div_diff    = div_shift - {1'b0, win};
  assign div_rem_nxt = div_ge ? div_diff[WB-1:0] : div_shift[WB-1:0];
  assign div_q_nxt   = {div_q_r[UB-2:0], div_ge};
  assign div_res     = div_neg_r ? (~div_q_nxt + 1'b1) : div_q_nxt;

  assign load_ok    = !out_tvalid_r || out_tready;
  // a word goes into the output register this cycle
  assign out_load   = load_ok && ((state_r == S_FIRST) || (state_r == S_AVG));
  assign last_first = (first_left_r == WB'(1)) && (avg_left_r == '0);

  // configuration
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == cma_pkg::REG_WINDOW);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == cma_pkg::REG_WINDOW) ?
                      {{(cma_pkg::DATA_BITS-WB){1'b0}}, wl_r} : '0;

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;

  // delay line write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_r;
    mem_wdata = in_tdata;
    if (in_acc && filling) begin
      mem_we = 1'b1;
    end else if (state_r == S_READ) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_r;
      mem_wdata = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wl_r         <= cma_pkg::WIN_RESET;
      fill_r       <= '0;
      ptr_r        <= '0;
      sum_r        <= '0;
      first_r      <= '0;
      avg_r        <= '0;
      end_r        <= 1'b0;
      first_left_r <= '0;
      avg_left_r   <= '0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr && (fill_r == '0)) begin
        wl_r <= cfg_pwdata[WB-1:0];
      end
      // a new word takes the register, else an accepted one leaves it
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            end_r <= in_tlast;
            x_r   <= in_tdata;
            if (filling) begin
              if (fill_r == '0) begin
                first_r <= in_tdata;
              end
              if (fill_inc == win) begin
                // window just filled: divide, then lead-in copies
                div_q_r      <= sum_fill[UB-1] ? UB'(-sum_fill) : UB'(sum_fill);
                div_neg_r    <= sum_fill[UB-1];
                div_rem_r    <= '0;
                div_cnt_r    <= '0;
                first_left_r <= half;
                avg_left_r   <= avg_cnt_in;
                state_r      <= S_DIV;
                if (in_tlast) begin
                  sum_r  <= '0;
                  fill_r <= '0;
                  ptr_r  <= '0;
                end else begin
                  sum_r  <= sum_fill;
                  fill_r <= fill_inc;
                end
              end else if (in_tlast) begin
                // short record: copies of the first sample
                first_left_r <= fill_inc;
                avg_left_r   <= '0;
                state_r      <= S_FIRST;
                sum_r        <= '0;
                fill_r       <= '0;
                ptr_r        <= '0;
              end else begin
                sum_r  <= sum_fill;
                fill_r <= fill_inc;
              end
            end else begin
              // oldest sample is being read at ptr_r
              state_r <= S_READ;
            end
          end
        end

        S_READ: begin
          div_q_r      <= sum_slide[UB-1] ? UB'(-sum_slide) : UB'(sum_slide);
          div_neg_r    <= sum_slide[UB-1];
          div_rem_r    <= '0;
          div_cnt_r    <= '0;
          first_left_r <= '0;
          avg_left_r   <= avg_cnt_x;
          state_r      <= S_DIV;
          if (end_r) begin
            sum_r  <= '0;
            fill_r <= '0;
            ptr_r  <= '0;
          end else begin
            sum_r <= sum_slide;
            ptr_r <= ptr_inc;
          end
        end

        S_DIV: begin
          div_q_r   <= div_q_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == CB'(cma_pkg::DIV_STEPS - 1)) begin
            avg_r   <= div_res[SB-1:0];
            state_r <= (first_left_r != '0) ? S_FIRST : S_AVG;
          end
        end

        S_FIRST: begin
          if (load_ok) begin
            out_data_r   <= first_r;
            out_last_r   <= last_first;
            out_done_r   <= last_first && end_r;
            first_left_r <= first_left_r - 1'b1;
            if (first_left_r == WB'(1)) begin
              state_r <= (avg_left_r != '0) ? S_AVG : S_IDLE;
            end
          end
        end

        S_AVG: begin
          if (load_ok) begin
            out_data_r   <= avg_r;
            out_last_r   <= (avg_left_r == WB'(1));
            out_done_r   <= (avg_left_r == WB'(1)) && end_r;
            avg_left_r   <= avg_left_r - 1'b1;
            if (avg_left_r == WB'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/centered_moving_average_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for centered_moving_average_core: stream driver, result monitor,
// built-in window-average predictor and apb window writes; depends on cma_pkg and the core
module centered_moving_average_core_tb;

  localparam int SAMPLE_BITS = cma_pkg::SAMPLE_BITS;
  localparam int MAX_WINDOW  = cma_pkg::MAX_WINDOW;
  localparam int WIN_BITS    = cma_pkg::WIN_BITS;
  localparam int SUM_BITS    = cma_pkg::SUM_BITS;
  localparam int ADDR_BITS   = cma_pkg::ADDR_BITS;
  localparam int DATA_BITS   = cma_pkg::DATA_BITS;
  localparam logic REG_WINDOW = cma_pkg::REG_WINDOW;
  localparam logic [WIN_BITS-1:0] WIN_RESET = cma_pkg::WIN_RESET;

  localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  // next word index, outside the register list, writes must be dropped
  localparam logic [ADDR_BITS-1:0] ADDR_UNUSED = {~REG_WINDOW, 2'b00};

  localparam int STALL_MAX    = 15;
  localparam int CFG_SETTLE   = 40;   // divider plus pipeline, core may still be busy
  localparam int END_SETTLE   = 100;
  localparam int IDLE_LIMIT   = 2000; // no handshake at all for this long means a hang
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 60;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          record_end;
  } sample_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          run_end;
    logic                          record_done;
  } average_word_t;

  typedef enum int {STYLE_ANY, STYLE_RAIL, STYLE_SMALL, STYLE_FLAT} sample_style_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_BITS-1:0] in_tdata    = '0;   // [15:0] sample
  logic                   in_tlast    = 1'b0; // record_end
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [SAMPLE_BITS-1:0] out_tdata;          // [15:0] average
  logic                   out_tlast;          // run_end
  logic [0:0]             out_tuser;          // [0] record_done
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]   cfg_paddr   = '0;
  logic [DATA_BITS-1:0]   cfg_pwdata  = '0;
  logic [DATA_BITS-1:0]   cfg_prdata;
  logic                   cfg_pready;

  // words waiting to be sent, and averages waiting to come out
  sample_word_t  sample_queue[$];
  average_word_t average_queue[$];

  // predictor copy of the core state
  logic signed [SAMPLE_BITS-1:0] tap_line [MAX_WINDOW];
  logic signed [SUM_BITS-1:0]    tap_sum;
  logic [WIN_BITS-1:0]           tap_count;
  logic signed [SAMPLE_BITS-1:0] record_first;
  logic signed [SAMPLE_BITS-1:0] held_average;
  logic [WIN_BITS-1:0]           window_reg;

  // per-phase idle depth for each side, 0 gives back-to-back traffic
  int send_gap_max   = 0;
  int recv_stall_max = 0;

  int gap_left;
  int stall_left;
  int stall_next;
  sample_word_t  on_bus;
  average_word_t want;

  int errors          = 0;
  int samples_in      = 0;
  int records_in      = 0;
  int results_checked = 0;
  int windows_used    = 0;
  int random_items    = 0;
  int idle_cycles     = 0;

  centered_moving_average_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic average_word_t plain_word(input logic signed [SAMPLE_BITS-1:0] value);
    average_word_t w;
    w.average     = value;
    w.run_end     = 1'b0;
    w.record_done = 1'b0;
    return w;
  endfunction

  // works out every average one accepted sample causes and queues them in order
  function automatic void smooth_sample(input sample_word_t word);
    int            win;
    int            half;
    average_word_t burst[$];
    win  = int'(window_reg | 6'd1);
    half = win / 2;
    if (int'(tap_count) < win) begin
      // window still filling
      if (tap_count == 0) begin
        record_first = word.sample;
      end
      tap_line[tap_count] = word.sample;
      tap_sum             = tap_sum + $signed(word.sample);
      tap_count           = tap_count + 1'b1;
      if (int'(tap_count) == win) begin
        // window just filled: leading edge copies, then the first real average
        repeat (half) burst.push_back(plain_word(record_first));
        held_average = SAMPLE_BITS'(int'(tap_sum) / win);
        burst.push_back(plain_word(held_average));
        if (word.record_end) begin
          repeat (half) burst.push_back(plain_word(held_average));
        end
      end else if (word.record_end) begin
        // record shorter than the window, one copy of the first sample per sample
        repeat (tap_count) burst.push_back(plain_word(record_first));
      end
    end else begin
      // steady state: slide the window by one
      tap_sum = tap_sum + $signed(word.sample) - $signed(tap_line[0]);
      for (int i = 0; i < win - 1; i++) begin
        tap_line[i] = tap_line[i + 1];
      end
      tap_line[win - 1] = word.sample;
      held_average      = SAMPLE_BITS'(int'(tap_sum) / win);
      burst.push_back(plain_word(held_average));
      if (word.record_end) begin
        // trailing edge holds the last average
        repeat (half) burst.push_back(plain_word(held_average));
      end
    end
    if (burst.size() != 0) begin
      burst[burst.size() - 1].run_end     = 1'b1;
      burst[burst.size() - 1].record_done = word.record_end;
    end
    if (word.record_end) begin
      tap_sum   = '0;
      tap_count = '0;
    end
    foreach (burst[i]) average_queue.push_back(burst[i]);
  endfunction

  // driver: feeds sample_queue onto the input stream and keeps the predictor in step,
  // including window writes seen on the config bus
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      gap_left     = 0;
      tap_sum      = '0;
      tap_count    = '0;
      record_first = '0;
      held_average = '0;
      window_reg   = WIN_RESET;
    end else begin
      // window only takes a new value between records
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_WINDOW && tap_count == 0) begin
        window_reg = cfg_pwdata[WIN_BITS-1:0];
      end
      if (in_tvalid && in_tready) begin
        smooth_sample(on_bus);
        samples_in++;
        if (on_bus.record_end) records_in++;
      end
      // the bus slot is free after this edge, present the next word or idle
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          on_bus    = sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= on_bus.sample;
          in_tlast  <= on_bus.record_end;
          gap_left  = $urandom_range(0, send_gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output word against the oldest queued average, random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      stall_next = stall_left;
      if (out_tvalid && out_tready) begin
        if (average_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: average=%0d run_end=%b record_done=%b",
                   $time, $signed(out_tdata), out_tlast, out_tuser[0]);
        end else begin
          want = average_queue.pop_front();
          results_checked++;
          if (want.average !== out_tdata || want.run_end !== out_tlast ||
              want.record_done !== out_tuser[0]) begin
            errors++;
            $display("%0t: mismatch: expected average=%0d run_end=%b record_done=%b, %s",
                     $time, want.average, want.run_end, want.record_done, "actual");
            $display("%0t:           actual   average=%0d run_end=%b record_done=%b",
                     $time, $signed(out_tdata), out_tlast, out_tuser[0]);
          end
        end
        stall_next = $urandom_range(0, recv_stall_max);
      end
      if (stall_next != 0) begin
        out_tready <= 1'b0;
        stall_left = stall_next - 1;
      end else begin
        out_tready <= 1'b1;
        stall_left = 0;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d averages still due",
                 $time, IDLE_LIMIT, average_queue.size());
        $display("centered_moving_average_core_tb: errors");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
    sample_word_t w;
    w.sample     = value;
    w.record_end = last;
    sample_queue.push_back(w);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_style_t style,
                                                         input logic [SAMPLE_BITS-1:0] flat);
    int tmp;
    case (style)
      STYLE_RAIL: begin
        return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      STYLE_SMALL: begin
        tmp = int'($urandom_range(0, 8)) - 4;
        return SAMPLE_BITS'(tmp);
      end
      STYLE_FLAT: begin
        return flat;
      end
      default: begin
        return SAMPLE_BITS'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic push_record(input int len);
    sample_style_t          style;
    logic [SAMPLE_BITS-1:0] flat;
    style = sample_style_t'($urandom_range(0, 3));
    flat  = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    for (int i = 0; i < len; i++) begin
      push_sample(pick_sample(style, flat), i == len - 1);
    end
    random_items += len;
  endtask

  // mostly records that get past the fill, some short ones and some exactly one window
  function automatic int pick_length(input int win);
    case ($urandom_range(0, 5))
      0:       return (win > 1) ? int'($urandom_range(1, win - 1)) : 1;
      1:       return win;
      default: return win + int'($urandom_range(1, 16));
    endcase
  endfunction

  // wait for every queued word to go in and every predicted average to come out,
  // checked on the falling edge once the rising-edge updates have settled
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_tvalid || average_queue.size() != 0);
  endtask

  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] value);
    drain();
    // a fill-phase sample leaves nothing to wait on, give the core time to settle
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic window_phase(input logic [WIN_BITS-1:0] setting);
    int win;
    int count;
    int len;
    // upper data bits are noise the register must not keep
    write_reg(ADDR_WINDOW, ($urandom() << WIN_BITS) | DATA_BITS'(setting));
    windows_used++;
    win            = int'(setting | 6'd1);
    send_gap_max   = $urandom_range(0, 1) ? STALL_MAX : 0;
    recv_stall_max = $urandom_range(0, 1) ? STALL_MAX : 0;
    count          = 0;
    while (count < PHASE_ITEMS) begin
      len = pick_length(win);
      push_record(len);
      count += len;
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    windows_used = 1;

    // directed, reset window of 9, no idling
    // single-sample record: one copy of itself
    push_sample(16'h8000, 1'b1);
    // record shorter than the window
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hffff, 1'b1);
    // record of exactly one window, rails alternate so the average truncates toward zero
    for (int i = 0; i < 9; i++) push_sample((i % 2) ? 16'h8000 : 16'h7fff, i == 8);
    // steady state and trailing edge
    for (int i = 0; i < 11; i++) push_sample(SAMPLE_BITS'((i % 2) ? -(i + 1) : i), i == 10);
    drain();

    // window writes in the middle of a record and to an unused address are dropped
    send_gap_max   = STALL_MAX;
    recv_stall_max = STALL_MAX;
    for (int i = 0; i < 3; i++) push_sample(SAMPLE_BITS'($urandom_range(0, 65535)), 1'b0);
    write_reg(ADDR_WINDOW, 32'd5);
    write_reg(ADDR_UNUSED, 32'd33);
    for (int i = 0; i < 7; i++) push_sample(SAMPLE_BITS'($urandom_range(0, 65535)), i == 6);
    write_reg(ADDR_UNUSED, 32'd3);
    for (int i = 0; i < 12; i++) push_sample(SAMPLE_BITS'($urandom_range(0, 65535)), i == 11);
    drain();

    // extremes of the window first, then random settings
    random_items = 0;
    window_phase(6'd0);
    window_phase(6'd1);
    window_phase(6'd2);
    window_phase(6'd63);
    window_phase(6'd62);
    window_phase(WIN_RESET);
    while (random_items < RANDOM_ITEMS) begin
      window_phase(WIN_BITS'($urandom_range(0, 63)));
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d samples in %0d records over %0d window settings",
             samples_in, records_in, windows_used);
    $display("%0d averages compared, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("centered_moving_average_core_tb: clean");
    end else begin
      $display("centered_moving_average_core_tb: errors");
    end
    $finish;
  end

endmodule
